FILE: rtl/kmp_pkg.sv
// shared constants, types and microcode table of the prefix-function block
`default_nettype none

package kmp_pkg;

    // store depth, derived widths and fixed symbol and length widths
    localparam int MAX_LEN = 1024;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int SYM_W   = 8;
    localparam int LEN_W   = 10;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [LEN_W-1:0] len_t;

    // microcode step addresses
    localparam int STEP_W = 2;
    typedef logic [STEP_W-1:0] step_t;
    localparam step_t STEP_FETCH = 2'd0;
    localparam step_t STEP_PROBE = 2'd1;
    localparam step_t STEP_HOLD  = 2'd2;

    // jump conditions
    localparam int COND_W = 3;
    typedef logic [COND_W-1:0] cond_t;
    localparam cond_t COND_NEVER     = 3'd0;
    localparam cond_t COND_NO_INPUT  = 3'd1;
    localparam cond_t COND_DIRECT    = 3'd2;
    localparam cond_t COND_FALLBACK  = 3'd3;
    localparam cond_t COND_SLOT_BUSY = 3'd4;

    // one control word: datapath strobes, two conditional jumps, fall-through
    typedef struct packed {
        logic  accept;
        logic  probe;
        logic  emit;
        cond_t cond_a;
        step_t tgt_a;
        cond_t cond_b;
        step_t tgt_b;
        step_t nxt;
    } uword_t;

    // strobes from sequencer to datapath
    typedef struct packed {
        logic accept;
        logic probe;
        logic emit;
    } dp_ctl_t;

    // status flags from datapath to sequencer
    typedef struct packed {
        logic no_input;
        logic direct;
        logic fallback;
        logic slot_busy;
    } dp_stat_t;

    // program rom
    function automatic uword_t ucode(input step_t step);
        uword_t w;
        begin
            case (step)
                // wait for a byte; bytes at position zero or in overflow go straight to hold
                STEP_FETCH: w = '{accept: 1'b1, probe: 1'b0, emit: 1'b0,
                                  cond_a: COND_NO_INPUT, tgt_a: STEP_FETCH,
                                  cond_b: COND_DIRECT,   tgt_b: STEP_HOLD,
                                  nxt: STEP_PROBE};
                // compare, fall back through borders, or finish
                STEP_PROBE: w = '{accept: 1'b0, probe: 1'b1, emit: 1'b1,
                                  cond_a: COND_FALLBACK,  tgt_a: STEP_PROBE,
                                  cond_b: COND_SLOT_BUSY, tgt_b: STEP_HOLD,
                                  nxt: STEP_FETCH};
                // deliver once the output register is free
                STEP_HOLD:  w = '{accept: 1'b0, probe: 1'b0, emit: 1'b1,
                                  cond_a: COND_SLOT_BUSY, tgt_a: STEP_HOLD,
                                  cond_b: COND_NEVER,     tgt_b: STEP_FETCH,
                                  nxt: STEP_FETCH};
                default:    w = '{accept: 1'b0, probe: 1'b0, emit: 1'b0,
                                  cond_a: COND_NEVER, tgt_a: STEP_FETCH,
                                  cond_b: COND_NEVER, tgt_b: STEP_FETCH,
                                  nxt: STEP_FETCH};
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/kmp_ifs.sv
// valid/ready channel interfaces for input bytes and results
`default_nettype none

interface kmp_in_if;
    logic          valid;
    logic          ready;
    kmp_pkg::sym_t symbol;
    logic          first;

    modport source (output valid, output symbol, output first, input ready);
    modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface kmp_out_if;
    logic          valid;
    logic          ready;
    kmp_pkg::len_t prefix_length;
    logic          overflow;

    modport source (output valid, output prefix_length, output overflow, input ready);
    modport sink   (input valid, input prefix_length, input overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/kmp_prefix_function.sv
// top level of the streaming prefix-function block
// a result is registered on delivery from probe, after any fall-back probe steps, or from hold
// a byte with no fall-back passes fetch then probe, set by the read-then-compare store loop
// fall-back steps are amortised below one per byte, one store read each
// first bytes and overflow bytes pass fetch then hold
// reset clears position, last border and the sequencer; stores keep no reset, no clearing pass
`default_nettype none

module kmp_prefix_function (
    input  wire logic clk,
    input  wire logic rst_n,
    kmp_in_if.sink    item,
    kmp_out_if.source result
);

    // strobes for the current microcode step
    kmp_pkg::dp_ctl_t  ctl;
    // flags the jumps are taken on
    kmp_pkg::dp_stat_t stat;

    // sequencer: fetch waits for a byte, probe compares against the symbol store
    // and walks back through the border store, hold parks a result until the
    // output register frees up
    kmp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // datapath: one read port per store, one write at delivery time; the
    // result register lets the next byte in while a result is still waiting
    kmp_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

`default_nettype wire

FILE: rtl/kmp_seq.sv
// microcode sequencer: step counter, program rom and conditional jumps
`default_nettype none

module kmp_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kmp_pkg::dp_stat_t stat,
    output kmp_pkg::dp_ctl_t       ctl
);

    kmp_pkg::step_t  step_reg;
    kmp_pkg::step_t  step_next;
    kmp_pkg::uword_t word;
    logic            take_a;
    logic            take_b;

    function automatic logic cond_hit(input kmp_pkg::cond_t c, input kmp_pkg::dp_stat_t s);
        logic hit;
        begin
            case (c)
                kmp_pkg::COND_NEVER:     hit = 1'b0;
                kmp_pkg::COND_NO_INPUT:  hit = s.no_input;
                kmp_pkg::COND_DIRECT:    hit = s.direct;
                kmp_pkg::COND_FALLBACK:  hit = s.fallback;
                kmp_pkg::COND_SLOT_BUSY: hit = s.slot_busy;
                default:                 hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

    always_comb
    begin
        word   = kmp_pkg::ucode(step_reg);
        take_a = cond_hit(word.cond_a, stat);
        take_b = cond_hit(word.cond_b, stat);
        if (take_a)
        begin
            step_next = word.tgt_a;
        end
        else if (take_b)
        begin
            step_next = word.tgt_b;
        end
        else
        begin
            step_next = word.nxt;
        end
        ctl.accept = word.accept;
        ctl.probe  = word.probe;
        // delivery only on the fall-through path
        ctl.emit   = word.emit & ~take_a & ~take_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= kmp_pkg::STEP_FETCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/kmp_dp.sv
// datapath: symbol and border stores, match pointer, position and output register
`default_nettype none

module kmp_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kmp_pkg::dp_ctl_t ctl,
    output kmp_pkg::dp_stat_t     stat,
    kmp_in_if.sink                item,
    kmp_out_if.source             result
);

    // stores
    kmp_pkg::sym_t sym_mem  [kmp_pkg::MAX_LEN];
    kmp_pkg::idx_t bord_mem [kmp_pkg::MAX_LEN];

    kmp_pkg::sym_t sym_rd;
    kmp_pkg::idx_t bord_rd;
    kmp_pkg::idx_t rd_sym_addr;
    kmp_pkg::idx_t rd_bord_addr;

    kmp_pkg::pos_t pos_reg;
    kmp_pkg::pos_t pos_next;
    kmp_pkg::idx_t prev_reg;
    kmp_pkg::idx_t prev_next;
    kmp_pkg::idx_t j_reg;
    kmp_pkg::sym_t sym_reg;
    logic          ovf_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    kmp_pkg::len_t len_reg;
    logic          res_ovf_reg;

    logic          in_fire;
    kmp_pkg::pos_t pos_eff;
    kmp_pkg::idx_t prev_eff;
    logic          ovf_in;
    kmp_pkg::idx_t j_start;
    logic          sym_match;
    logic          fallback;
    kmp_pkg::idx_t next_j;
    kmp_pkg::idx_t j_final;
    kmp_pkg::idx_t emit_j;
    logic          wr_en;

    assign item.ready = ctl.accept;
    assign in_fire    = item.valid & ctl.accept;

    always_comb
    begin
        pos_eff  = item.first ? '0 : pos_reg;
        prev_eff = item.first ? '0 : prev_reg;
        ovf_in   = pos_eff >= kmp_pkg::POS_W'(kmp_pkg::MAX_LEN);
        if (pos_eff == '0 || kmp_pkg::POS_W'(prev_eff) >= pos_eff)
        begin
            j_start = '0;
        end
        else
        begin
            j_start = prev_eff;
        end

        sym_match = sym_reg == sym_rd;
        fallback  = (j_reg != '0) & ~sym_match;
        next_j    = (bord_rd < j_reg) ? bord_rd : '0;
        j_final   = j_reg + kmp_pkg::IDX_W'(sym_match);
        emit_j    = ctl.probe ? j_final : j_reg;

        rd_sym_addr  = ctl.accept ? j_start : next_j;
        rd_bord_addr = rd_sym_addr - kmp_pkg::IDX_W'(1);

        wr_en = ctl.emit & ~ovf_reg;

        stat.no_input  = ~item.valid;
        stat.direct    = ovf_in | (pos_eff == '0);
        stat.fallback  = fallback;
        stat.slot_busy = out_valid_reg & ~result.ready;
    end

    // store write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            sym_mem[pos_reg[kmp_pkg::IDX_W-1:0]] <= sym_reg;
        end
        sym_rd <= sym_mem[rd_sym_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bord_mem[pos_reg[kmp_pkg::IDX_W-1:0]] <= emit_j;
        end
        bord_rd <= bord_mem[rd_bord_addr];
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sym_reg <= item.symbol;
            ovf_reg <= ovf_in;
            j_reg   <= j_start;
        end
        else if (ctl.probe)
        begin
            j_reg <= fallback ? next_j : j_final;
        end
        if (ctl.emit)
        begin
            len_reg     <= ovf_reg ? '0 : kmp_pkg::LEN_W'(emit_j);
            res_ovf_reg <= ovf_reg;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        prev_next = prev_reg;
        if (in_fire)
        begin
            pos_next  = pos_eff;
            prev_next = prev_eff;
        end
        else if (wr_en)
        begin
            pos_next  = pos_reg + kmp_pkg::POS_W'(1);
            prev_next = emit_j;
        end
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.prefix_length = len_reg;
    assign result.overflow      = res_ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/kmp_chk.sv
// port-level checker for the prefix-function block, bound to the top level
`default_nettype none

module kmp_chk (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          in_valid,
    input wire logic          in_ready,
    input wire logic          out_valid,
    input wire logic          out_ready,
    input wire kmp_pkg::len_t prefix_length,
    input wire logic          overflow
);

    logic       in_fire;
    logic       out_fire;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign in_fire  = in_valid & in_ready;
    assign out_fire = out_valid & out_ready;

    // bytes taken but not yet answered
    always_comb
    begin
        cnt_next = cnt_reg + 2'(in_fire) - 2'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(prefix_length) && $stable(overflow))
        else $error("result changed while stalled");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> prefix_length == '0)
        else $error("overflow result with nonzero length");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> cnt_reg != 2'd0)
        else $error("result without a byte");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("too many bytes in flight");

endmodule

bind kmp_prefix_function kmp_chk u_kmp_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (item.valid),
    .in_ready      (item.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .prefix_length (result.prefix_length),
    .overflow      (result.overflow)
);

`default_nettype wire
